// File: hw/rtl/best_fit_range_allocator_top_defines.svh
// assertion macros used by the checker file
`ifndef BEST_FIT_RANGE_ALLOCATOR_TOP_DEFINES_SVH
`define BEST_FIT_RANGE_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define BFRA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfra check failed");

// next-cycle implication, sampled on clk, off during reset
`define BFRA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfra check failed");

`endif

// File: hw/rtl/bfra_pkg.sv
package bfra_pkg;

    // one table entry: a free byte range
    typedef struct packed {
        logic        valid;
        logic [31:0] off;
        logic [31:0] size;
    } entry_t;

    // control from the engine to every ring cell
    typedef struct packed {
        logic shift;
        logic load;
    } ring_ctrl_t;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_NOFIT  = 3'd1,
        ST_ZERO   = 3'd2,
        ST_DOUBLE = 3'd3,
        ST_FULL   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_APPLY,
        S_FIX,
        S_DONE
    } state_t;

    localparam int          POOL_W     = 12;
    localparam int          MIB_SHIFT  = 20;
    localparam logic [11:0] RESET_POOL = 12'd64;
    localparam logic [31:0] NO_OFFSET  = 32'hFFFF_FFFF;

    // pool size in bytes from the MiB count
    function automatic logic [31:0] pool_bytes(input logic [POOL_W-1:0] mb);
        pool_bytes = {mb, {MIB_SHIFT{1'b0}}};
    endfunction

endpackage

// File: hw/rtl/best_fit_range_allocator_top.sv
// Best-fit free-range allocator. The free table is a ring of MAX_FREE_BLOCKS
// cells that, while a request is worked on, rotates one entry per cycle past
// a single compare engine. Allocate and free take one rotation to search
// and, unless the request fails, one to update; an allocate whose remainder
// offset is already held takes one more rotation. Clear, zero size and the
// unused op code skip the rotations. One request is worked on at a time;
// a finished result word sits in the output register while the next
// request is taken. The user must write the pool size (cfg_we/cfg_wdata)
// only while idle; the block does not enforce it. Takes effect on the next clear.
module best_fit_range_allocator_top #(
    parameter int MAX_FREE_BLOCKS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [11:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [31:0] block_offset,
    input  logic [31:0] block_size,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_offset,
    output logic [2:0]  status,
    output logic [6:0]  free_block_count
);
    import bfra_pkg::*;

    logic [POOL_W-1:0] pool_reg;
    ring_ctrl_t        ctrl;
    entry_t            head;
    entry_t            cell_out [MAX_FREE_BLOCKS];

    // pool size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pool_reg <= RESET_POOL;
        else if (cfg_we)
            pool_reg <= cfg_wdata;
    end

    // ring of table cells
    genvar i;
    generate
        for (i = 0; i < MAX_FREE_BLOCKS; i++)
        begin : g_cell
            bfra_cell #(
                .FIRST (i == 0)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .pool_mb   (pool_reg),
                .entry_in  ((i == 0) ? head : cell_out[(i == 0) ? 0 : i - 1]),
                .entry_out (cell_out[i])
            );
        end
    endgenerate

    // search and update engine at the ring head
    bfra_engine #(
        .MAX_FREE_BLOCKS (MAX_FREE_BLOCKS)
    ) u_engine (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .op               (op),
        .block_offset     (block_offset),
        .block_size       (block_size),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .result_offset    (result_offset),
        .status           (status),
        .free_block_count (free_block_count),
        .pool_mb          (pool_reg),
        .tail             (cell_out[MAX_FREE_BLOCKS-1]),
        .head             (head),
        .ctrl             (ctrl)
    );

endmodule

// File: hw/rtl/bfra_cell.sv
module bfra_cell #(
    parameter bit FIRST = 1'b0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bfra_pkg::ring_ctrl_t        ctrl,
    input  logic [bfra_pkg::POOL_W-1:0] pool_mb,
    input  bfra_pkg::entry_t            entry_in,
    output bfra_pkg::entry_t            entry_out
);
    import bfra_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // clear loads the whole-pool block into the first cell only; a shift takes the previous cell's entry
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load)
        begin
            entry_next.valid = FIRST && (pool_mb != '0);
            entry_next.off   = '0;
            entry_next.size  = pool_bytes(pool_mb);
        end
        else if (ctrl.shift)
        begin
            entry_next = entry_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg.valid <= FIRST;
            entry_reg.off   <= '0;
            entry_reg.size  <= FIRST ? pool_bytes(RESET_POOL) : '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry_out = entry_reg;

endmodule

// File: hw/rtl/bfra_engine.sv
module bfra_engine #(
    parameter int MAX_FREE_BLOCKS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  op,
    input  logic [31:0]                 block_offset,
    input  logic [31:0]                 block_size,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [31:0]                 result_offset,
    output logic [2:0]                  status,
    output logic [6:0]                  free_block_count,
    input  logic [bfra_pkg::POOL_W-1:0] pool_mb,
    input  bfra_pkg::entry_t            tail,
    output bfra_pkg::entry_t            head,
    output bfra_pkg::ring_ctrl_t        ctrl
);
    import bfra_pkg::*;

    localparam int IW = $clog2(MAX_FREE_BLOCKS);
    localparam int HW = $clog2(MAX_FREE_BLOCKS + 1);
    localparam logic [IW-1:0] LAST = IW'(MAX_FREE_BLOCKS - 1);
    localparam logic [HW-1:0] FULL = HW'(MAX_FREE_BLOCKS);

    state_t state_reg, state_next;

    logic [IW-1:0] idx_reg;
    logic [IW-1:0] k_reg;
    logic [HW-1:0] held_reg;
    logic [1:0]    op_reg;
    logic [31:0]   off_reg, size_reg, end_reg;
    logic          end_ovf_reg;
    // scan results
    logic          bfound_reg, dbl_reg, nfound_reg, pfound_reg;
    logic [31:0]   bsize_reg, boff_reg, nsize_reg, poff_reg, psize_reg;
    // decision results
    logic          next_ok_reg, prev_ok_reg, dup_reg, ins_reg;
    logic [31:0]   roff_reg, rest_reg, msz_reg;
    logic [2:0]    st_reg;
    logic [31:0]   res_reg;
    // output word
    logic          out_valid_reg;
    logic [31:0]   out_off_reg;
    logic [2:0]    out_st_reg;
    logic [6:0]    out_cnt_reg;

    logic          accept, last, out_free, is_alloc, dup_now, ins_now;
    logic          cand, better;
    logic [32:0]   nsum, pend, msum, end_sum;
    logic          next_ok, prev_ok, full;
    logic [31:0]   msize1, msz;

    assign accept   = in_valid && !in_stall;
    assign last     = (idx_reg == LAST);
    assign out_free = !out_valid_reg || !out_stall;
    assign is_alloc = (op_reg == OP_ALLOC);
    assign end_sum  = {1'b0, block_offset} + {1'b0, block_size};

    // best-fit candidate test on the entry leaving the ring
    assign cand   = tail.valid && (tail.size >= size_reg);
    assign better = !bfound_reg || (tail.size < bsize_reg) ||
                    ((tail.size == bsize_reg) && (tail.off < boff_reg));

    // merge decision after the scan
    always_comb
    begin
        nsum    = {1'b0, size_reg} + {1'b0, nsize_reg};
        next_ok = nfound_reg && !nsum[32];
        msize1  = next_ok ? nsum[31:0] : size_reg;
        pend    = {1'b0, poff_reg} + {1'b0, psize_reg};
        msum    = {1'b0, msize1} + {1'b0, psize_reg};
        prev_ok = pfound_reg && (pend == {1'b0, off_reg}) && !msum[32];
        msz     = prev_ok ? msum[31:0] : msize1;
        full    = !next_ok && !prev_ok && (held_reg >= FULL);
    end

    // entry modification at the ring head
    always_comb
    begin
        head    = tail;
        dup_now = 1'b0;
        ins_now = 1'b0;
        if (state_reg == S_APPLY && is_alloc)
        begin
            if (tail.valid && tail.off == boff_reg)
            begin
                head.valid = (rest_reg != '0);
                head.off   = roff_reg;
                head.size  = rest_reg;
            end
            else if (tail.valid && tail.off == roff_reg)
            begin
                dup_now = 1'b1;
            end
        end
        else if (state_reg == S_APPLY)
        begin
            if (prev_ok_reg && tail.valid && tail.off == poff_reg)
            begin
                head.size = msz_reg;
            end
            else if (next_ok_reg && tail.valid && tail.off == end_reg)
            begin
                head.valid = !prev_ok_reg;
                head.off   = off_reg;
                head.size  = msz_reg;
            end
            else if (!next_ok_reg && !prev_ok_reg && !tail.valid && !ins_reg)
            begin
                ins_now    = 1'b1;
                head.valid = 1'b1;
                head.off   = off_reg;
                head.size  = msz_reg;
            end
        end
        else if (state_reg == S_FIX && idx_reg == k_reg)
        begin
            head.valid = 1'b0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((op == OP_ALLOC || op == OP_FREE) && block_size != '0)
                        state_next = S_SCAN;
                    else
                        state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                if (last)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (is_alloc)
                    state_next = bfound_reg ? S_APPLY : S_DONE;
                else
                    state_next = (dbl_reg || full) ? S_DONE : S_APPLY;
            end
            S_APPLY:
            begin
                if (last)
                begin
                    if (is_alloc && (dup_reg || dup_now) && rest_reg != '0)
                        state_next = S_FIX;
                    else
                        state_next = S_DONE;
                end
            end
            S_FIX:
            begin
                if (last)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // handshake and ring control
    always_comb
    begin
        in_stall   = (state_reg != S_IDLE);
        ctrl.shift = (state_reg == S_SCAN) || (state_reg == S_APPLY) ||
                     (state_reg == S_FIX);
        ctrl.load  = (state_reg == S_IDLE) && in_valid && (op == OP_CLEAR);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            held_reg      <= HW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctrl.shift)
                idx_reg <= last ? '0 : idx_reg + 1'b1;
            if (ctrl.load)
                held_reg <= HW'(pool_mb != '0);
            else if (state_reg == S_DECIDE && is_alloc && bfound_reg)
                held_reg <= held_reg - HW'(bsize_reg == size_reg ? 1 : 0);
            else if (state_reg == S_DECIDE && !is_alloc && !dbl_reg && !full)
                held_reg <= held_reg + 1'b1 - HW'(next_ok) - HW'(prev_ok);
            else if (state_reg == S_FIX && idx_reg == k_reg)
                held_reg <= held_reg - 1'b1;
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= op;
            off_reg     <= block_offset;
            size_reg    <= block_size;
            end_reg     <= end_sum[31:0];
            end_ovf_reg <= end_sum[32];
            bfound_reg  <= 1'b0;
            dbl_reg     <= 1'b0;
            nfound_reg  <= 1'b0;
            pfound_reg  <= 1'b0;
            dup_reg     <= 1'b0;
            ins_reg     <= 1'b0;
            res_reg     <= NO_OFFSET;
            st_reg      <= ((op == OP_ALLOC || op == OP_FREE) && block_size == '0)
                           ? ST_ZERO : ST_OK;
        end
        // scan: one entry per cycle
        if (state_reg == S_SCAN)
        begin
            if (cand && better)
            begin
                bfound_reg <= 1'b1;
                bsize_reg  <= tail.size;
                boff_reg   <= tail.off;
            end
            if (tail.valid && tail.off == off_reg)
                dbl_reg <= 1'b1;
            if (tail.valid && !end_ovf_reg && tail.off == end_reg)
            begin
                nfound_reg <= 1'b1;
                nsize_reg  <= tail.size;
            end
            if (tail.valid && tail.off < off_reg &&
                (!pfound_reg || tail.off > poff_reg))
            begin
                pfound_reg <= 1'b1;
                poff_reg   <= tail.off;
                psize_reg  <= tail.size;
            end
        end
        // decide
        if (state_reg == S_DECIDE)
        begin
            next_ok_reg <= next_ok;
            prev_ok_reg <= prev_ok;
            msz_reg     <= msz;
            roff_reg    <= boff_reg + size_reg;
            rest_reg    <= bsize_reg - size_reg;
            if (is_alloc)
            begin
                if (bfound_reg)
                    res_reg <= boff_reg;
                else
                    st_reg <= ST_NOFIT;
            end
            else if (dbl_reg)
                st_reg <= ST_DOUBLE;
            else if (full)
                st_reg <= ST_FULL;
        end
        // apply
        if (state_reg == S_APPLY)
        begin
            if (dup_now)
                dup_reg <= 1'b1;
            if (ins_now)
                ins_reg <= 1'b1;
            if (is_alloc && tail.valid && tail.off == boff_reg)
                k_reg <= idx_reg;
        end
        // output word
        if (state_reg == S_DONE && out_free)
        begin
            out_off_reg <= res_reg;
            out_st_reg  <= st_reg;
            out_cnt_reg <= 7'(held_reg);
        end
    end

    assign out_valid        = out_valid_reg;
    assign result_offset    = out_off_reg;
    assign status           = out_st_reg;
    assign free_block_count = out_cnt_reg;

endmodule

// File: hw/rtl/bfra_checker.sv
`include "best_fit_range_allocator_top_defines.svh"

module bfra_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] result_offset,
    input logic [2:0]  status
);
    import bfra_pkg::*;

    // a waiting result word stays up
    `BFRA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    // one request at a time: busy right after a word is taken
    `BFRA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    // results with a status other than OK carry no offset
    `BFRA_ASSERT_NOW(a_fail_no_offset, out_valid && status != ST_OK,
        result_offset == NO_OFFSET)
    // a result word never comes out the cycle after a request is taken
    `BFRA_ASSERT_NEXT(a_no_instant_result, in_valid && !in_stall && !out_valid,
        !out_valid)

endmodule

bind best_fit_range_allocator_top bfra_checker u_bfra_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_offset (result_offset),
    .status        (status)
);

// File: bench/tb_top.sv
module tb_top;
    import bfra_pkg::*;

    localparam int NUM_ENTRIES  = 64;
    localparam int SETTLE_WAIT  = 4 * NUM_ENTRIES + 20;
    localparam int WATCHDOG_MAX = 20000;

    // free table image and pool register
    typedef struct {
        bit          valid [NUM_ENTRIES];
        bit [31:0]   offs  [NUM_ENTRIES];
        bit [31:0]   sizes [NUM_ENTRIES];
        int          held;
        bit [11:0]   pool_mb;
    } range_table_t;

    typedef struct {
        logic [31:0] offset;
        status_t     st;
        logic [6:0]  count;
    } alloc_word_t;

    typedef struct {
        op_t         op;
        logic [31:0] offset;
        logic [31:0] size;
    } request_t;

    typedef struct {
        bit [31:0] offset;
        bit [31:0] size;
    } grant_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [11:0] cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  op;
    logic [31:0] block_offset;
    logic [31:0] block_size;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] result_offset;
    logic [2:0]  status;
    logic [6:0]  free_block_count;

    range_table_t chk_table;
    range_table_t gen_table;
    request_t     pending_q [$];
    alloc_word_t  expected_q [$];
    grant_t       granted_q [$];
    int           error_count;
    int           idle_cycles;
    int           burst_left;
    int           gap_left;
    int           stall_left;
    int           stall_mode;

    best_fit_range_allocator_top #(.MAX_FREE_BLOCKS(NUM_ENTRIES)) dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .op(op),
        .block_offset(block_offset), .block_size(block_size),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_offset(result_offset), .status(status),
        .free_block_count(free_block_count)
    );

    always #5 clk = ~clk;

    // table helpers
    function automatic int find_at(input range_table_t t, input bit [31:0] off);
        for (int i = 0; i < NUM_ENTRIES; i++)
            if (t.valid[i] && t.offs[i] == off)
                return i;
        return -1;
    endfunction

    function automatic void table_clear(inout range_table_t t);
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            t.valid[i] = 0;
            t.offs[i]  = '0;
            t.sizes[i] = '0;
        end
        t.held = 0;
        if (t.pool_mb != 0)
        begin
            t.valid[0] = 1;
            t.sizes[0] = {t.pool_mb, 20'd0};
            t.held     = 1;
        end
    endfunction

    function automatic void drop_slot(inout range_table_t t, input int i);
        t.valid[i] = 0;
        t.offs[i]  = '0;
        t.sizes[i] = '0;
        t.held--;
    endfunction

    function automatic void fill_slot(inout range_table_t t, input int i,
                                      input bit [31:0] off, input bit [31:0] size);
        t.valid[i] = 1;
        t.offs[i]  = off;
        t.sizes[i] = size;
        t.held++;
    endfunction

    // best fit, lowest offset on ties; remainder kept unless its offset is held
    function automatic status_t best_fit_take(inout range_table_t t, input bit [31:0] size,
                                              output bit [31:0] got);
        int best;
        bit [31:0] boff;
        bit [31:0] bsize;
        bit [31:0] rest;
        best = -1;
        got  = NO_OFFSET;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            if (!t.valid[i] || t.sizes[i] < size)
                continue;
            if (best < 0 || t.sizes[i] < t.sizes[best] ||
                (t.sizes[i] == t.sizes[best] && t.offs[i] < t.offs[best]))
                best = i;
        end
        if (best < 0)
            return ST_NOFIT;
        boff  = t.offs[best];
        bsize = t.sizes[best];
        drop_slot(t, best);
        rest = bsize - size;
        if (rest != 0 && find_at(t, boff + size) < 0)
            fill_slot(t, best, boff + size, rest);
        got = boff;
        return ST_OK;
    endfunction

    // give a range back, merging with neighbors that touch it
    function automatic status_t range_release(inout range_table_t t, input bit [31:0] off,
                                              input bit [31:0] size);
        bit [32:0] end_pos;
        bit [32:0] msize;
        bit [31:0] moff;
        int nxt;
        int prv;
        int slot;
        end_pos = {1'b0, off} + {1'b0, size};
        msize   = {1'b0, size};
        moff    = off;
        nxt     = -1;
        prv     = -1;
        if (find_at(t, off) >= 0)
            return ST_DOUBLE;
        if (!end_pos[32])
        begin
            nxt = find_at(t, end_pos[31:0]);
            if (nxt >= 0 && (msize + {1'b0, t.sizes[nxt]}) > 33'hFFFF_FFFF)
                nxt = -1;
        end
        if (nxt >= 0)
            msize += {1'b0, t.sizes[nxt]};
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            if (!t.valid[i] || i == nxt || t.offs[i] >= off)
                continue;
            if (prv < 0 || t.offs[i] > t.offs[prv])
                prv = i;
        end
        if (prv >= 0)
            if (({1'b0, t.offs[prv]} + {1'b0, t.sizes[prv]}) != {1'b0, off} ||
                (msize + {1'b0, t.sizes[prv]}) > 33'hFFFF_FFFF)
                prv = -1;
        if (nxt < 0 && prv < 0 && t.held >= NUM_ENTRIES)
            return ST_FULL;
        if (nxt >= 0)
            drop_slot(t, nxt);
        if (prv >= 0)
        begin
            msize += {1'b0, t.sizes[prv]};
            moff = t.offs[prv];
            drop_slot(t, prv);
        end
        slot = -1;
        for (int i = 0; i < NUM_ENTRIES; i++)
            if (slot < 0 && !t.valid[i])
                slot = i;
        if (slot >= 0)
            fill_slot(t, slot, moff, msize[31:0]);
        return ST_OK;
    endfunction

    // expected word for one request
    function automatic alloc_word_t serve_request(inout range_table_t t, input request_t rq);
        alloc_word_t w;
        bit [31:0] got;
        w.offset = NO_OFFSET;
        w.st     = ST_OK;
        case (rq.op)
            OP_ALLOC:
                if (rq.size == 0)
                    w.st = ST_ZERO;
                else
                begin
                    w.st = best_fit_take(t, rq.size, got);
                    w.offset = got;
                end
            OP_FREE:
                if (rq.size == 0)
                    w.st = ST_ZERO;
                else
                    w.st = range_release(t, rq.offset, rq.size);
            OP_CLEAR:
                table_clear(t);
            default: ;
        endcase
        w.count = t.held[6:0];
        return w;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // queue one request, tracking grants on the generator side
    task automatic queue_req(input op_t o, input logic [31:0] off, input logic [31:0] size);
        request_t rq;
        alloc_word_t w;
        rq.op     = o;
        rq.offset = off;
        rq.size   = size;
        w = serve_request(gen_table, rq);
        if (o == OP_CLEAR)
            granted_q.delete();
        if (o == OP_ALLOC && w.st == ST_OK)
            granted_q.push_back('{w.offset, size});
        pending_q.push_back(rq);
    endtask

    // wait for the block to drain, then let it settle
    task automatic drain_all();
        while (pending_q.size() != 0 || in_valid || expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_pool(input logic [11:0] mb);
        drain_all();
        cfg_we    <= 1'b1;
        cfg_wdata <= mb;
        @(posedge clk);
        cfg_we    <= 1'b0;
        chk_table.pool_mb = mb;
        gen_table.pool_mb = mb;
    endtask

    function automatic logic [31:0] pick_size(input bit [11:0] mb);
        case ($urandom_range(0, 9))
            0:       return {mb, 20'd0} >> $urandom_range(0, 6);
            1:       return $urandom_range(1, 1 << 20);
            default: return $urandom_range(1, 4096);
        endcase
    endfunction

    // mostly well-formed alloc/free traffic, some noise
    task automatic random_phase(input int count);
        int pick;
        int k;
        grant_t g;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40 && granted_q.size() != 0)
            begin
                k = $urandom_range(0, granted_q.size() - 1);
                g = granted_q[k];
                granted_q.delete(k);
                queue_req(OP_FREE, g.offset, g.size);
            end
            else if (pick < 82)
                queue_req(OP_ALLOC, 0, pick_size(gen_table.pool_mb));
            else if (pick < 86 && gen_table.held != 0)
            begin
                k = $urandom_range(0, NUM_ENTRIES - 1);
                queue_req(OP_FREE, gen_table.offs[k], $urandom_range(1, 64));
            end
            else if (pick < 88)
                queue_req(OP_CLEAR, $urandom(), $urandom());
            else
                queue_req(op_t'($urandom_range(0, 3)), $urandom(),
                          ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom());
        end
    endtask

    // sender: bursts with gaps
    always @(posedge clk)
    begin
        request_t rq;
        if (in_valid && !in_stall)
            expected_q.push_back(serve_request(chk_table,
                                 '{op_t'(op), block_offset, block_size}));
        if (!(in_valid && in_stall))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (rst_n && pending_q.size() != 0)
            begin
                rq = pending_q.pop_front();
                in_valid     <= 1'b1;
                op           <= rq.op;
                block_offset <= rq.offset;
                block_size   <= rq.size;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: stall pattern and result checking
    always @(posedge clk)
    begin
        alloc_word_t w;
        if (out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $display("unexpected result word at %0t", $time);
                error_count++;
            end
            else
            begin
                w = expected_q.pop_front();
                if (result_offset !== w.offset)
                    report("result_offset", result_offset, w.offset);
                if (status !== w.st)
                    report("status", status, w.st);
                if (free_block_count !== w.count)
                    report("free_block_count", free_block_count, w.count);
            end
        end
        if (stall_left <= 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 600);
        end
        stall_left--;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= $urandom_range(0, 1);
            default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        in_valid     = 1'b0;
        op           = OP_NOP;
        block_offset = '0;
        block_size   = '0;
        out_stall    = 1'b0;
        error_count  = 0;
        idle_cycles  = 0;
        burst_left   = 1;
        gap_left     = 0;
        stall_left   = 0;
        stall_mode   = 0;
        chk_table.pool_mb = RESET_POOL;
        gen_table.pool_mb = RESET_POOL;
        table_clear(chk_table);
        table_clear(gen_table);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero size, fits, no fit, double free, merges, nop
        queue_req(OP_ALLOC, 0, 0);
        queue_req(OP_FREE, 32'h40, 0);
        queue_req(OP_ALLOC, 32'hFFFF_FFFF, 1);
        queue_req(OP_ALLOC, 0, 32'hFFFF_FFFF);
        queue_req(OP_FREE, 1, 5);
        queue_req(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(OP_FREE, 0, 1);
        queue_req(OP_ALLOC, 0, 32'h0400_0000);
        queue_req(OP_CLEAR, 0, 0);
        // remainder offset already held gets dropped
        queue_req(OP_FREE, 16, 8);
        queue_req(OP_ALLOC, 0, 16);
        // ranges running past the top of the address space
        queue_req(OP_FREE, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
        queue_req(OP_FREE, 32'hFFFF_FFFF, 1);
        queue_req(OP_FREE, 32'h8000_0000, 32'h8000_0000);
        queue_req(OP_ALLOC, 0, 32'h7FFF_FFFF);
        queue_req(OP_CLEAR, 0, 0);
        random_phase(200);

        // empty pool, then fill the table past its depth
        write_pool(12'd0);
        queue_req(OP_CLEAR, 0, 0);
        queue_req(OP_ALLOC, 0, 1);
        for (int i = 0; i < NUM_ENTRIES + 2; i++)
            queue_req(OP_FREE, i * 32, 16);
        queue_req(OP_FREE, 32'h1_0000, 32'h1_0000);
        queue_req(OP_FREE, 16, 16);
        random_phase(100);

        write_pool(12'd1);
        queue_req(OP_CLEAR, 0, 0);
        random_phase(250);

        write_pool(12'd4095);
        queue_req(OP_CLEAR, 0, 0);
        queue_req(OP_FREE, 32'hFFF0_0000, 32'h0010_0000);
        queue_req(OP_ALLOC, 0, 32'hFFF0_0000);
        random_phase(200);

        write_pool(12'd2);
        queue_req(OP_CLEAR, 0, 0);
        random_phase(250);

        write_pool(12'($urandom_range(1, 4095)));
        queue_req(OP_CLEAR, 0, 0);
        random_phase(200);

        drain_all();
        if (error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
